### sv/bgp_pkg.sv
// Shared types, constants and helper functions for the glyph placer.
// Used by every module of the block but bgp_ram; depends on nothing.
`timescale 1ns / 1ps

package bgp_pkg;

  // Glyph table geometry
  localparam int GLYPH_COUNT = 96;
  localparam int GLYPH_IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CODE_NEWLINE    = 8'd10;
  localparam logic [7:0] CODE_SPACE      = 8'd32;
  localparam logic [7:0] CODE_GLYPH_BASE = 8'd33;

  // Input action codes
  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_CHAR = 1'b1;

  // Register reset values
  localparam logic [11:0] ORIGIN_X_RST    = 12'd0;
  localparam logic [11:0] ORIGIN_Y_RST    = 12'd0;
  localparam logic [11:0] CLIP_WIDTH_RST  = 12'd320;
  localparam logic [11:0] CLIP_HEIGHT_RST = 12'd256;
  localparam logic [7:0]  FONT_HEIGHT_RST = 8'd8;
  localparam logic [7:0]  SPACE_WIDTH_RST = 8'd4;

  typedef enum logic [2:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_CLIP_WIDTH  = 3'd2,
    REG_CLIP_HEIGHT = 3'd3,
    REG_FONT_HEIGHT = 3'd4,
    REG_SPACE_WIDTH = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_OTHER   = 2'd0,
    KIND_NEWLINE = 2'd1,
    KIND_SPACE   = 2'd2,
    KIND_GLYPH   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [11:0] clip_width;
    logic [11:0] clip_height;
    logic [7:0]  font_height;
    logic [7:0]  space_width;
  } cfg_t;

  typedef struct packed {
    logic [15:0] row;
    logic [7:0]  width;
  } glyph_entry_t;

  typedef struct packed {
    kind_t        kind;
    logic         last;
    glyph_entry_t entry;
  } queue_item_t;

  function automatic logic [15:0] sat16(input logic [16:0] v);
    logic [15:0] r;
    r = v[16] ? 16'hFFFF : v[15:0];
    return r;
  endfunction

  function automatic logic [12:0] sat13(input logic [16:0] v);
    logic [12:0] r;
    r = (v[16:13] != 4'd0) ? 13'h1FFF : v[12:0];
    return r;
  endfunction

  // Rows left for glyphs on the current line, zero once the pen reaches the clip height
  function automatic logic [7:0] row_height_f(input logic [7:0] font,
                                              input logic [11:0] clip,
                                              input logic [15:0] pen_y);
    logic [11:0] diff;
    logic [7:0]  r;
    diff = clip - pen_y[11:0];
    if (pen_y < {4'd0, clip}) begin
      r = ({4'd0, font} < diff) ? font : diff[7:0];
    end else begin
      r = 8'd0;
    end
    return r;
  endfunction

endpackage

### sv/bitmap_text_glyph_placer_top.sv
// Path: a character is loaded into the front register when accepted, then enters
// the queue and then reaches the output register, from which its blit transfers;
// held while stalled.
// Throughput: one item per cycle unless stalled, set by the pen update in bgp_back.
// Reset: synchronous, active-low rst_n; registers take their reset values, the
// pen goes home and the queue empties. The glyph table is not cleared: load it first.
// Top level of the glyph placer. Depends on bgp_pkg, bgp_front, bgp_queue,
// bgp_back and bgp_ram.
`timescale 1ns / 1ps

module bitmap_text_glyph_placer_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [6:0]  in_glyph_index,
  input  logic [15:0] in_glyph_row,
  input  logic [7:0]  in_glyph_width,
  input  logic [7:0]  in_char_code,
  input  logic        in_last,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [12:0] out_dest_x,
  output logic [12:0] out_dest_y,
  output logic [15:0] out_source_row,
  output logic [7:0]  out_blit_width,
  output logic [7:0]  out_blit_height,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  bgp_pkg::cfg_t                     cfg_r, cfg_nxt;
  logic                              rh_refresh;
  logic                              q_push;
  bgp_pkg::queue_item_t              q_push_item;
  logic                              q_pop;
  logic                              q_valid;
  bgp_pkg::queue_item_t              q_item;
  logic [bgp_pkg::QUEUE_CNT_W-1:0]   q_count;

  // Register writes are always accepted
  assign cfg_ready = 1'b1;

  // Decode a register transfer; clip or font height changes also refresh
  // the row height held in the back end.
  always_comb begin
    cfg_nxt    = cfg_r;
    rh_refresh = 1'b0;
    if (cfg_valid) begin
      case (bgp_pkg::reg_idx_t'(cfg_index))
        bgp_pkg::REG_ORIGIN_X:    cfg_nxt.origin_x    = cfg_data;
        bgp_pkg::REG_ORIGIN_Y:    cfg_nxt.origin_y    = cfg_data;
        bgp_pkg::REG_CLIP_WIDTH:  cfg_nxt.clip_width  = cfg_data;
        bgp_pkg::REG_CLIP_HEIGHT: begin
          cfg_nxt.clip_height = cfg_data;
          rh_refresh          = 1'b1;
        end
        bgp_pkg::REG_FONT_HEIGHT: begin
          cfg_nxt.font_height = cfg_data[7:0];
          rh_refresh          = 1'b1;
        end
        bgp_pkg::REG_SPACE_WIDTH: cfg_nxt.space_width = cfg_data[7:0];
        default: begin
          // Drop writes beyond the register list
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x    <= bgp_pkg::ORIGIN_X_RST;
      cfg_r.origin_y    <= bgp_pkg::ORIGIN_Y_RST;
      cfg_r.clip_width  <= bgp_pkg::CLIP_WIDTH_RST;
      cfg_r.clip_height <= bgp_pkg::CLIP_HEIGHT_RST;
      cfg_r.font_height <= bgp_pkg::FONT_HEIGHT_RST;
      cfg_r.space_width <= bgp_pkg::SPACE_WIDTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: take items, fill the glyph table, classify and look up glyphs
  bgp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_glyph_index (in_glyph_index),
    .in_glyph_row   (in_glyph_row),
    .in_glyph_width (in_glyph_width),
    .in_char_code   (in_char_code),
    .in_last        (in_last),
    .q_count        (q_count),
    .push           (q_push),
    .push_item      (q_push_item)
  );

  // Queue: lets the front keep accepting while the output is stalled
  bgp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_item),
    .count     (q_count)
  );

  // Back end: advance the pen, clip and emit blit commands
  bgp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .cfg_next        (cfg_nxt),
    .rh_refresh      (rh_refresh),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_dest_x      (out_dest_x),
    .out_dest_y      (out_dest_y),
    .out_source_row  (out_source_row),
    .out_blit_width  (out_blit_width),
    .out_blit_height (out_blit_height)
  );

endmodule

### sv/bgp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bgp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/bgp_front.sv
// Front end: accepts items, writes glyph table loads, classifies characters
// and reads the glyph table. Depends on bgp_pkg and bgp_ram.
`timescale 1ns / 1ps

module bgp_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  logic [6:0]                          in_glyph_index,
  input  logic [15:0]                         in_glyph_row,
  input  logic [7:0]                          in_glyph_width,
  input  logic [7:0]                          in_char_code,
  input  logic                                in_last,
  input  logic [bgp_pkg::QUEUE_CNT_W-1:0]     q_count,
  output logic                                push,
  output bgp_pkg::queue_item_t                push_item
);

  logic                           s1_valid_r, s1_valid_nxt;
  bgp_pkg::kind_t                 s1_kind_r, s1_kind_nxt;
  logic                           s1_last_r, s1_last_nxt;
  logic                           accept;
  logic [bgp_pkg::QUEUE_CNT_W:0]  used;
  logic [7:0]                     code_off;
  logic                           is_glyph;
  logic                           tbl_we;
  bgp_pkg::glyph_entry_t          tbl_wdata;
  bgp_pkg::glyph_entry_t          tbl_rdata;

  // Reserve a slot for the item still waiting on its table read
  assign used     = {1'b0, q_count} + (bgp_pkg::QUEUE_CNT_W + 1)'(s1_valid_r);
  assign in_stall = (used >= (bgp_pkg::QUEUE_CNT_W + 1)'(bgp_pkg::QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;

  assign code_off = in_char_code - bgp_pkg::CODE_GLYPH_BASE;
  assign is_glyph = (in_char_code >= bgp_pkg::CODE_GLYPH_BASE) &&
                    ({1'b0, code_off} < 9'(bgp_pkg::GLYPH_COUNT));

  assign tbl_we = accept && (in_action == bgp_pkg::ACTION_LOAD) &&
                  ({2'b0, in_glyph_index} < 9'(bgp_pkg::GLYPH_COUNT));
  assign tbl_wdata.row   = in_glyph_row;
  assign tbl_wdata.width = in_glyph_width;

  bgp_ram #(
    .WIDTH ($bits(bgp_pkg::glyph_entry_t)),
    .DEPTH (bgp_pkg::GLYPH_COUNT)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (bgp_pkg::GLYPH_IDX_W'(in_glyph_index)),
    .wdata (tbl_wdata),
    .raddr (bgp_pkg::GLYPH_IDX_W'(code_off)),
    .rdata (tbl_rdata)
  );

  always_comb begin
    s1_valid_nxt = accept && (in_action == bgp_pkg::ACTION_CHAR);
    s1_last_nxt  = in_last;
    if (in_char_code == bgp_pkg::CODE_NEWLINE) begin
      s1_kind_nxt = bgp_pkg::KIND_NEWLINE;
    end else if (in_char_code == bgp_pkg::CODE_SPACE) begin
      s1_kind_nxt = bgp_pkg::KIND_SPACE;
    end else if (is_glyph) begin
      s1_kind_nxt = bgp_pkg::KIND_GLYPH;
    end else begin
      s1_kind_nxt = bgp_pkg::KIND_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    s1_kind_r <= s1_kind_nxt;
    s1_last_r <= s1_last_nxt;
  end

  assign push            = s1_valid_r;
  assign push_item.kind  = s1_kind_r;
  assign push_item.last  = s1_last_r;
  assign push_item.entry = tbl_rdata;

endmodule

### sv/bgp_queue.sv
// Short FIFO that decouples the front end from the pen logic.
// Depends on bgp_pkg.
`timescale 1ns / 1ps

module bgp_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  bgp_pkg::queue_item_t             push_item,
  input  logic                             pop,
  output logic                             pop_valid,
  output bgp_pkg::queue_item_t             pop_item,
  output logic [bgp_pkg::QUEUE_CNT_W-1:0]  count
);

  bgp_pkg::queue_item_t                 slots_r [bgp_pkg::QUEUE_DEPTH];
  logic [bgp_pkg::QUEUE_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [bgp_pkg::QUEUE_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [bgp_pkg::QUEUE_CNT_W-1:0]      count_r, count_nxt;
  logic                                 do_pop;

  assign pop_valid = (count_r != '0);
  assign pop_item  = slots_r[rd_ptr_r];
  assign count     = count_r;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == bgp_pkg::QUEUE_PTR_W'(bgp_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == bgp_pkg::QUEUE_PTR_W'(bgp_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### sv/bgp_back.sv
// Back end: pen state, clipping and the registered blit output.
// Depends on bgp_pkg.
`timescale 1ns / 1ps

module bgp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bgp_pkg::cfg_t         cfg,
  input  bgp_pkg::cfg_t         cfg_next,
  input  logic                  rh_refresh,
  input  logic                  q_valid,
  input  bgp_pkg::queue_item_t  q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [12:0]           out_dest_x,
  output logic [12:0]           out_dest_y,
  output logic [15:0]           out_source_row,
  output logic [7:0]            out_blit_width,
  output logic [7:0]            out_blit_height
);

  logic [15:0] pen_x_r, pen_x_nxt;
  logic [15:0] pen_y_r, pen_y_nxt;
  logic [7:0]  row_h_r, row_h_nxt;
  logic        stopped_r, stopped_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [12:0] dest_x_r, dest_x_nxt;
  logic [12:0] dest_y_r, dest_y_nxt;
  logic [15:0] src_row_r, src_row_nxt;
  logic [7:0]  blit_w_r, blit_w_nxt;
  logic [7:0]  blit_h_r, blit_h_nxt;
  logic        out_free;
  logic        emit;
  logic [15:0] py_new;
  logic [11:0] avail;
  logic [7:0]  w;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = q_valid && out_free;

  always_comb begin
    pen_x_nxt   = pen_x_r;
    pen_y_nxt   = pen_y_r;
    row_h_nxt   = row_h_r;
    stopped_nxt = stopped_r;
    emit        = 1'b0;
    py_new      = bgp_pkg::sat16({1'b0, pen_y_r} + 17'(cfg.font_height));
    avail       = cfg.clip_width - pen_x_r[11:0];
    w           = ({4'd0, q_item.entry.width} < avail) ? q_item.entry.width : avail[7:0];
    dest_x_nxt  = bgp_pkg::sat13(17'(cfg.origin_x) + 17'(pen_x_r));
    dest_y_nxt  = bgp_pkg::sat13(17'(cfg.origin_y) + 17'(pen_y_r));
    src_row_nxt = q_item.entry.row;
    blit_w_nxt  = w;
    blit_h_nxt  = row_h_r;

    if (rh_refresh) begin
      row_h_nxt = bgp_pkg::row_height_f(cfg_next.font_height, cfg_next.clip_height,
                                        pen_y_r);
    end

    if (q_pop) begin
      if (!stopped_r) begin
        case (q_item.kind)
          bgp_pkg::KIND_NEWLINE: begin
            pen_x_nxt = 16'd0;
            pen_y_nxt = py_new;
            if (py_new >= {4'd0, cfg.clip_height}) begin
              stopped_nxt = 1'b1;
            end else begin
              row_h_nxt = bgp_pkg::row_height_f(cfg.font_height, cfg.clip_height, py_new);
            end
          end
          bgp_pkg::KIND_SPACE: begin
            pen_x_nxt = bgp_pkg::sat16({1'b0, pen_x_r} + 17'(cfg.space_width));
          end
          bgp_pkg::KIND_GLYPH: begin
            if (pen_x_r < {4'd0, cfg.clip_width}) begin
              emit      = (w != 8'd0) && (row_h_r != 8'd0);
              pen_x_nxt = bgp_pkg::sat16({1'b0, pen_x_r} + 17'(w));
            end
          end
          default: begin
          end
        endcase
      end
      // End of string: send the pen home
      if (q_item.last) begin
        pen_x_nxt   = 16'd0;
        pen_y_nxt   = 16'd0;
        stopped_nxt = 1'b0;
        row_h_nxt   = bgp_pkg::row_height_f(cfg.font_height, cfg.clip_height, 16'd0);
      end
    end

    if (out_free) begin
      out_valid_nxt = q_pop && emit;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r     <= 16'd0;
      pen_y_r     <= 16'd0;
      stopped_r   <= 1'b0;
      row_h_r     <= bgp_pkg::row_height_f(bgp_pkg::FONT_HEIGHT_RST,
                                           bgp_pkg::CLIP_HEIGHT_RST, 16'd0);
      out_valid_r <= 1'b0;
    end else begin
      pen_x_r     <= pen_x_nxt;
      pen_y_r     <= pen_y_nxt;
      stopped_r   <= stopped_nxt;
      row_h_r     <= row_h_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (q_pop && emit) begin
      dest_x_r  <= dest_x_nxt;
      dest_y_r  <= dest_y_nxt;
      src_row_r <= src_row_nxt;
      blit_w_r  <= blit_w_nxt;
      blit_h_r  <= blit_h_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_dest_x      = dest_x_r;
  assign out_dest_y      = dest_y_r;
  assign out_source_row  = src_row_r;
  assign out_blit_width  = blit_w_r;
  assign out_blit_height = blit_h_r;

endmodule
